// ----- hdl/strided_slice_address_generator_assert.svh -----
// Assertion macros for the slice address generator.
`ifndef STRIDED_SLICE_ADDRESS_GENERATOR_ASSERT_SVH
`define STRIDED_SLICE_ADDRESS_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SSAG_ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define SSAG_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SSAG_ASSERT_IMPL(label, clk, rst_n, cond, msg)
`define SSAG_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- hdl/ssag_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ssag_pkg;
    localparam int MAX_RANK_DEF    = 4;
    localparam int DIM_BITS_DEF    = 16;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int WORD_BITS       = 64;
    localparam int SLOT_BITS       = 16;
    localparam int MASK_BITS       = 12;
    localparam int RANK_BITS       = 3;
    localparam int CFG_IDX_BITS    = 3;
    localparam int STATUS_BITS     = 3;
    localparam int OUT_OFS_BITS    = 32;
    localparam int NUM_AXES        = 4;

    localparam logic [CFG_IDX_BITS-1:0] REG_SHAPE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BEGIN  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_END    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MASKS  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANK   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLICE  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SWAP   = 3'd7;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_ZERO    = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_BOUND   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_SHRINK  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic start;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic [STATUS_BITS-1:0] status;
        logic                   last;
    } t_stat;

    function automatic logic [1:0] axis_src(input logic [1:0] d, input logic swap);
        logic [1:0] r;
        r = d;
        if (swap) begin
            unique case (d)
                2'd0: r = 2'd0;
                2'd1: r = 2'd3;
                2'd2: r = 2'd1;
                default: r = 2'd2;
            endcase
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- hdl/ssag_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ssag_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic          i_restart,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ssag_pkg::t_cmd     o_cmd,
    input  ssag_pkg::t_stat    i_stat
);
    import ssag_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_OUT   = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_active, n_active;
    logic       accept, out_take;

    assign out_take    = o_out_valid && !i_out_stall;
    assign o_out_valid = (r_state == S_OUT);
    assign o_in_stall  = !((r_state == S_IDLE) || (r_state == S_OUT && out_take));
    assign accept      = i_in_valid && !o_in_stall;

    always_comb begin
        n_state   = r_state;
        n_active  = r_active;
        o_cmd     = '0;
        if (out_take) begin
            n_state = S_IDLE;
        end
        if (accept) begin
            if (i_restart || !r_active) begin
                o_cmd.start = 1'b1;
                n_state = S_SETUP;
            end else begin
                o_cmd.step = 1'b1;
                n_active = !i_stat.last;
                n_state = S_OUT;
            end
        end
        if (r_state == S_SETUP && i_stat.done) begin
            if (i_stat.status == ST_OK) begin
                o_cmd.step = 1'b1;
                n_active = !i_stat.last;
            end else begin
                n_active = 1'b0;
            end
            n_state = S_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/ssag_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ssag_datapath #(
    parameter int MAX_RANK    = ssag_pkg::MAX_RANK_DEF,
    parameter int DIM_BITS    = ssag_pkg::DIM_BITS_DEF,
    parameter int OFFSET_BITS = ssag_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [ssag_pkg::WORD_BITS-1:0]     i_shape,
    input  wire logic [ssag_pkg::WORD_BITS-1:0]     i_begin,
    input  wire logic [ssag_pkg::WORD_BITS-1:0]     i_end,
    input  wire logic [ssag_pkg::WORD_BITS-1:0]     i_stride,
    input  wire logic [ssag_pkg::MASK_BITS-1:0]     i_masks,
    input  wire logic [ssag_pkg::RANK_BITS-1:0]     i_rank,
    input  wire logic                               i_slice,
    input  wire logic                               i_swap,
    input  ssag_pkg::t_cmd                          i_cmd,
    output ssag_pkg::t_stat                         o_stat,
    output logic [ssag_pkg::OUT_OFS_BITS-1:0]       o_offset,
    output logic                                    o_last,
    output logic [ssag_pkg::STATUS_BITS-1:0]        o_status,
    output logic [ssag_pkg::SLOT_BITS-1:0]          o_len [ssag_pkg::NUM_AXES]
);
    import ssag_pkg::*;

    localparam int VB = 20;
    localparam int AX = NUM_AXES;

    // setup sequencer phases
    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_NORM  = 3'd1;
    localparam logic [2:0] P_DIV   = 3'd2;
    localparam logic [2:0] P_PLACE = 3'd3;
    localparam logic [2:0] P_DONE  = 3'd4;

    logic [2:0]               r_phase;
    logic [1:0]               r_ax;
    logic [4:0]               r_bit;
    logic [RANK_BITS-1:0]     r_rank;
    logic [STATUS_BITS-1:0]   r_err;
    logic [2:0]               r_nout;

    logic signed [VB-1:0]     r_pos  [AX];
    logic signed [VB-1:0]     r_beg  [AX];
    logic signed [VB-1:0]     r_end  [AX];
    logic signed [VB-1:0]     r_str  [AX];
    logic [SLOT_BITS-1:0]     r_len  [AX];
    logic [SLOT_BITS-1:0]     r_dim  [AX];
    logic [OFFSET_BITS-1:0]   r_pv   [AX];
    logic [AX-1:0]            r_shr;

    logic [VB-1:0]            r_num, r_den, r_quo, r_rem;

    logic [OUT_OFS_BITS-1:0]  r_offset;
    logic                     r_last;
    logic [STATUS_BITS-1:0]   r_status;
    logic [SLOT_BITS-1:0]     r_olen [AX];

    logic [RANK_BITS-1:0]     rank_c;
    logic                     swap_c;
    logic [1:0]               src;
    logic signed [VB-1:0]     n_c, b_c, e_c, s_c, bb, ee, lo, hi, bn, en, x;
    logic                     bm, em, sm;
    logic [AX-1:0]            fin;
    logic                     all_fin;
    logic [OFFSET_BITS-1:0]   ofs;
    logic [OFFSET_BITS-1:0]   prod [AX];
    logic signed [VB-1:0]     diff;
    logic [VB-1:0]            rem_sh;
    logic [2:0]               ax_ext;

    assign rank_c = (i_rank == '0) ? RANK_BITS'(1)
                  : ((32'(i_rank) > MAX_RANK) ? RANK_BITS'(MAX_RANK) : i_rank);
    assign swap_c = i_swap && (rank_c == RANK_BITS'(4));
    assign src    = axis_src(r_ax, swap_c);
    assign ax_ext = {1'b0, r_ax};
    assign diff   = r_end[r_ax] - r_beg[r_ax];

    always_comb begin
        n_c = VB'(signed'({1'b0, i_shape[SLOT_BITS*r_ax +: SLOT_BITS]
                   & SLOT_BITS'((32'd1 << DIM_BITS) - 1)}));
        b_c = VB'(signed'(i_begin[SLOT_BITS*src +: SLOT_BITS]));
        e_c = VB'(signed'(i_end[SLOT_BITS*src +: SLOT_BITS]));
        s_c = VB'(signed'(i_stride[SLOT_BITS*src +: SLOT_BITS]));
        bm  = i_masks[src];
        em  = i_masks[4 + 32'(src)];
        sm  = i_masks[8 + 32'(src)];
        lo  = (s_c > 0) ? '0 : -VB'(1);
        hi  = (s_c > 0) ? n_c : n_c - VB'(1);
        bn  = (b_c < 0) ? b_c + n_c : b_c;
        en  = (e_c < 0) ? e_c + n_c : e_c;
        bb  = bm ? ((s_c > 0) ? '0 : n_c - VB'(1))
                 : ((bn < lo) ? lo : ((bn > hi) ? hi : bn));
        ee  = em ? ((s_c > 0) ? n_c : -VB'(1))
                 : ((en < lo) ? lo : ((en > hi) ? hi : en));
        x   = bn;
        if (i_slice && e_c == -VB'(1)) begin
            e_c = n_c - b_c;
        end
    end

    always_comb begin
        for (int d = 0; d < AX; d++) begin
            fin[d] = (r_str[d] > 0) ? (r_pos[d] + r_str[d] >= r_end[d])
                                    : (r_pos[d] + r_str[d] <= r_end[d]);
            prod[d] = OFFSET_BITS'(r_pos[d][SLOT_BITS-1:0]) * r_pv[d];
        end
        all_fin = 1'b1;
        ofs = '0;
        for (int d = 0; d < AX; d++) begin
            if (d < 32'(r_rank)) begin
                all_fin = all_fin & fin[d];
                ofs = ofs + prod[d];
            end
        end
    end

    assign rem_sh = {r_rem[VB-2:0], r_num[VB-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_ax    <= '0;
            r_bit   <= '0;
            r_rank  <= RANK_BITS'(1);
            r_err   <= ST_OK;
            r_nout  <= '0;
            for (int d = 0; d < AX; d++) begin
                r_len[d]  <= '0;
                r_olen[d] <= '0;
            end
            r_status <= ST_OK;
            r_last   <= 1'b0;
            r_offset <= '0;
        end else begin
            if (i_cmd.start) begin
                r_phase <= P_NORM;
                r_ax    <= '0;
                r_rank  <= rank_c;
                r_err   <= ST_OK;
                r_nout  <= '0;
                for (int d = 0; d < AX; d++) begin
                    r_len[d] <= '0;
                end
            end
            unique case (r_phase)
                P_NORM: begin
                    r_dim[r_ax] <= n_c[SLOT_BITS-1:0];
                    if (ax_ext < r_rank) begin
                        if (!i_slice && s_c == 0) begin
                            r_err <= ST_ZERO;
                        end else if (r_err == ST_OK) begin
                            if (i_slice) begin
                                if (b_c < 0 || b_c > n_c || e_c < 0 || b_c + e_c > n_c) begin
                                    r_err <= ST_BOUND;
                                end
                                r_beg[r_ax] <= b_c;
                                r_end[r_ax] <= b_c + e_c;
                                r_str[r_ax] <= VB'(1);
                                r_shr[r_ax] <= 1'b0;
                                r_len[r_nout[1:0]] <= e_c[SLOT_BITS-1:0];
                                r_nout <= r_nout + 3'd1;
                            end else if (sm) begin
                                if (x < 0 || x >= n_c) begin
                                    r_err <= ST_SHRINK;
                                end
                                r_beg[r_ax] <= x;
                                r_end[r_ax] <= x + VB'(1);
                                r_str[r_ax] <= VB'(1);
                                r_shr[r_ax] <= 1'b1;
                            end else begin
                                r_beg[r_ax] <= bb;
                                r_end[r_ax] <= ee;
                                r_str[r_ax] <= s_c;
                                r_shr[r_ax] <= 1'b0;
                            end
                        end
                    end
                    if (r_ax == 2'd3) begin
                        r_ax <= '0;
                        r_phase <= i_slice ? P_PLACE : P_DIV;
                    end else begin
                        r_ax <= r_ax + 2'd1;
                    end
                end
                P_DIV: begin
                    // one quotient bit a cycle per axis
                    if (r_err != ST_OK || ax_ext >= r_rank || r_shr[r_ax]) begin
                        if (r_ax == 2'd3 || r_err != ST_OK) begin
                            r_phase <= P_PLACE;
                            r_ax <= '0;
                        end else begin
                            r_ax <= r_ax + 2'd1;
                        end
                        r_bit <= '0;
                    end else if (r_bit == '0) begin
                        if (r_str[r_ax] > 0) begin
                            r_num <= (diff <= 0) ? '0 : VB'(diff + r_str[r_ax] - VB'(1));
                            r_den <= VB'(r_str[r_ax]);
                        end else begin
                            r_num <= (diff >= 0) ? '0 : VB'(-diff - r_str[r_ax] - VB'(1));
                            r_den <= VB'(-r_str[r_ax]);
                        end
                        r_rem <= '0;
                        r_quo <= '0;
                        r_bit <= 5'd1;
                    end else if (r_bit <= 5'(VB)) begin
                        if (rem_sh >= r_den) begin
                            r_rem <= rem_sh - r_den;
                            r_quo <= {r_quo[VB-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_quo <= {r_quo[VB-2:0], 1'b0};
                        end
                        r_num <= {r_num[VB-2:0], 1'b0};
                        r_bit <= r_bit + 5'd1;
                    end else begin
                        r_len[r_nout[1:0]] <= r_quo[SLOT_BITS-1:0];
                        r_nout <= r_nout + 3'd1;
                        r_bit <= '0;
                        if (r_ax == 2'd3) begin
                            r_phase <= P_PLACE;
                            r_ax <= '0;
                        end else begin
                            r_ax <= r_ax + 2'd1;
                        end
                    end
                end
                P_PLACE: begin
                    // place values from the innermost axis outward, one a cycle
                    if (r_ax == 2'd0) begin
                        for (int d = 0; d < AX; d++) begin
                            r_pos[d] <= r_beg[d];
                        end
                        r_pv[r_rank[1:0] - 2'd1] <= OFFSET_BITS'(1);
                        r_ax <= r_rank[1:0] - 2'd1;
                        if (r_rank == RANK_BITS'(1)) begin
                            r_phase <= P_DONE;
                        end
                    end else begin
                        r_pv[r_ax - 2'd1] <= r_pv[r_ax] * OFFSET_BITS'(r_dim[r_ax]);
                        if (r_ax == 2'd1) begin
                            r_phase <= P_DONE;
                        end
                        r_ax <= r_ax - 2'd1;
                    end
                    if (r_err == ST_OK) begin
                        for (int d = 0; d < AX; d++) begin
                            if (d < 32'(r_nout) && r_len[d] == '0) begin
                                r_err <= ST_EMPTY;
                            end
                        end
                    end
                end
                P_DONE: begin
                    r_phase <= P_IDLE;
                    if (r_err != ST_OK) begin
                        r_status <= r_err;
                        r_offset <= '0;
                        r_last   <= 1'b1;
                        for (int d = 0; d < AX; d++) begin
                            r_olen[d] <= (r_err == ST_EMPTY) ? r_len[d] : '0;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.step) begin
                r_offset <= OUT_OFS_BITS'(ofs);
                r_last   <= all_fin;
                r_status <= ST_OK;
                for (int d = 0; d < AX; d++) begin
                    r_olen[d] <= r_len[d];
                end
                if (!all_fin) begin
                    for (int d = AX - 1; d >= 0; d--) begin
                        if (d < 32'(r_rank)) begin
                            if (fin[d]) begin
                                r_pos[d] <= r_beg[d];
                            end else begin
                                r_pos[d] <= r_pos[d] + r_str[d];
                                break;
                            end
                        end
                    end
                end
            end
        end
    end

    assign o_stat.busy   = (r_phase != P_IDLE);
    assign o_stat.done   = (r_phase == P_DONE);
    assign o_stat.status = r_err;
    assign o_stat.last   = all_fin;
    assign o_offset      = r_offset;
    assign o_last        = r_last;
    assign o_status      = r_status;
    assign o_len         = r_olen;
endmodule
`default_nettype wire

// ----- hdl/strided_slice_address_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake              | payload
// input    | i_in_valid/o_in_stall  | i_restart
// output   | o_out_valid/i_out_stall| o_source_offset, o_last_element, o_status, o_out_len_*
// config   | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
// Within a walk, the result register loads at the accepting edge, and the next step
// is accepted at the edge that takes the result. A walk setup runs the normalise,
// divide and place phases before its result; slice mode skips the bit-serial divider
// for the output lengths. Reset is synchronous, active low. A stalled result holds;
// no new step is accepted until it leaves.
module strided_slice_address_generator #(
    parameter int MAX_RANK    = ssag_pkg::MAX_RANK_DEF,
    parameter int DIM_BITS    = ssag_pkg::DIM_BITS_DEF,
    parameter int OFFSET_BITS = ssag_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_restart,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [ssag_pkg::OUT_OFS_BITS-1:0]        o_source_offset,
    output logic                                     o_last_element,
    output logic [ssag_pkg::STATUS_BITS-1:0]         o_status,
    output logic [ssag_pkg::SLOT_BITS-1:0]           o_out_len_a,
    output logic [ssag_pkg::SLOT_BITS-1:0]           o_out_len_b,
    output logic [ssag_pkg::SLOT_BITS-1:0]           o_out_len_c,
    output logic [ssag_pkg::SLOT_BITS-1:0]           o_out_len_d,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [ssag_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [ssag_pkg::WORD_BITS-1:0]      i_cfg_data
);
    import ssag_pkg::*;

    logic [WORD_BITS-1:0] r_shape, r_begin, r_end, r_stride;
    logic [MASK_BITS-1:0] r_masks;
    logic [RANK_BITS-1:0] r_rank;
    logic                 r_slice, r_swap;
    t_cmd                 cmd;
    t_stat                stat;
    logic [SLOT_BITS-1:0] len [NUM_AXES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape  <= '0;
            r_begin  <= '0;
            r_end    <= '0;
            r_stride <= '0;
            r_masks  <= '0;
            r_rank   <= RANK_BITS'(1);
            r_slice  <= 1'b0;
            r_swap   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SHAPE:  r_shape  <= i_cfg_data;
                REG_BEGIN:  r_begin  <= i_cfg_data;
                REG_END:    r_end    <= i_cfg_data;
                REG_STRIDE: r_stride <= i_cfg_data;
                REG_MASKS:  r_masks  <= i_cfg_data[MASK_BITS-1:0];
                REG_RANK:   r_rank   <= i_cfg_data[RANK_BITS-1:0];
                REG_SLICE:  r_slice  <= i_cfg_data[0];
                default:    r_swap   <= i_cfg_data[0];
            endcase
        end
    end

    ssag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    ssag_datapath #(
        .MAX_RANK    (MAX_RANK),
        .DIM_BITS    (DIM_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shape  (r_shape),
        .i_begin  (r_begin),
        .i_end    (r_end),
        .i_stride (r_stride),
        .i_masks  (r_masks),
        .i_rank   (r_rank),
        .i_slice  (r_slice),
        .i_swap   (r_swap),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_offset (o_source_offset),
        .o_last   (o_last_element),
        .o_status (o_status),
        .o_len    (len)
    );

    assign o_out_len_a = len[0];
    assign o_out_len_b = len[1];
    assign o_out_len_c = len[2];
    assign o_out_len_d = len[3];

`include "strided_slice_address_generator_assert.svh"

    `SSAG_ASSERT_IMPL(a_no_start_busy, i_clk, i_rst_n, !(cmd.start && stat.busy), "start while busy")
    `SSAG_ASSERT_IMPL(a_err_last, i_clk, i_rst_n, !(o_out_valid && o_status != ST_OK) || o_last_element, "error without last")
    `SSAG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped")
endmodule
`default_nettype wire
